/* src/assert_macros.svh */
// Assertion macros for the collision unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define LBMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that holds while reset is applied.
`define LBMC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) !arst_n |-> prop) else $error(msg);

`endif

/* src/lbmc_pkg.sv */
// Types, constants and fixed-point helpers for the D2Q9 collision unit.
package lbmc_pkg;

	localparam int QW        = 32;
	localparam int NPOP      = 9;
	localparam int NUM_W     = 37;
	localparam int RELAX_W   = 26;
	localparam int FORCE_W   = 25;
	localparam int CFG_W     = 26;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_LAT   = 34;
	localparam int LANE_LAT  = 7;
	localparam int SIDE_LAT  = DIV_LAT + 2;
	localparam int PIPE_LAT  = 2 + SIDE_LAT + LANE_LAT;

	localparam logic [RELAX_W-1:0] RELAX_RESET = 26'd16777216;
	localparam logic [FORCE_W-1:0] FORCE_RESET = 25'd8388608;

	typedef logic signed [QW-1:0] q_t;

	localparam q_t Q_MAX = 32'sh7FFFFFFF;
	localparam q_t Q_MIN = 32'sh80000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RELAX_RATE   = 1'b0,
		CFG_FORCE_FACTOR = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		q_t [NPOP-1:0] f;
		q_t            fy;
		q_t            rho;
	} side_t;

	typedef struct packed {
		q_t [NPOP-1:0] post;
		q_t            density;
		q_t            vel_x;
		q_t            vel_y;
	} post_t;

	function automatic logic signed [1:0] dir_x(input logic [3:0] p);
		case (p)
			4'd1, 4'd2, 4'd8: return 2'sd1;
			4'd4, 4'd5, 4'd6: return -2'sd1;
			default:          return 2'sd0;
		endcase
	endfunction

	function automatic logic signed [1:0] dir_y(input logic [3:0] p);
		case (p)
			4'd6, 4'd7, 4'd8: return 2'sd1;
			4'd2, 4'd3, 4'd4: return -2'sd1;
			default:          return 2'sd0;
		endcase
	endfunction

	function automatic q_t weight(input logic [3:0] p);
		case (p)
			4'd0:             return 32'sd7456540;
			4'd1, 4'd3, 4'd5,
			4'd7:             return 32'sd1864135;
			default:          return 32'sd466034;
		endcase
	endfunction

	function automatic q_t sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return Q_MAX;
		end else if (x < -64'sd2147483648) begin
			return Q_MIN;
		end
		return x[QW-1:0];
	endfunction

	// Q8.24 product with round-half-up, then clamp.
	function automatic q_t mulq(input q_t a, input q_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat32((p + 64'sd8388608) >>> 24);
	endfunction

endpackage

/* src/lbmc_if.sv */
// Request and result channels of the collision unit.
interface lbmc_cell_if;
	logic         valid;
	logic         ready;
	lbmc_pkg::q_t pop_rest;
	lbmc_pkg::q_t pop_east;
	lbmc_pkg::q_t pop_east_south;
	lbmc_pkg::q_t pop_south;
	lbmc_pkg::q_t pop_west_south;
	lbmc_pkg::q_t pop_west;
	lbmc_pkg::q_t pop_west_north;
	lbmc_pkg::q_t pop_north;
	lbmc_pkg::q_t pop_east_north;
	lbmc_pkg::q_t force_x;
	lbmc_pkg::q_t force_y;

	modport source (output valid, pop_rest, pop_east, pop_east_south, pop_south,
		pop_west_south, pop_west, pop_west_north, pop_north, pop_east_north,
		force_x, force_y, input ready);
	modport sink (input valid, pop_rest, pop_east, pop_east_south, pop_south,
		pop_west_south, pop_west, pop_west_north, pop_north, pop_east_north,
		force_x, force_y, output ready);
endinterface

interface lbmc_post_if;
	logic         valid;
	logic         ready;
	lbmc_pkg::q_t post_rest;
	lbmc_pkg::q_t post_east;
	lbmc_pkg::q_t post_east_south;
	lbmc_pkg::q_t post_south;
	lbmc_pkg::q_t post_west_south;
	lbmc_pkg::q_t post_west;
	lbmc_pkg::q_t post_west_north;
	lbmc_pkg::q_t post_north;
	lbmc_pkg::q_t post_east_north;
	lbmc_pkg::q_t density;
	lbmc_pkg::q_t velocity_x;
	lbmc_pkg::q_t velocity_y;

	modport source (output valid, post_rest, post_east, post_east_south, post_south,
		post_west_south, post_west, post_west_north, post_north, post_east_north,
		density, velocity_x, velocity_y, input ready);
	modport sink (input valid, post_rest, post_east, post_east_south, post_south,
		post_west_south, post_west, post_west_north, post_north, post_east_north,
		density, velocity_x, velocity_y, output ready);
endinterface

/* src/lbm_d2q9_moments_collide_forced_unit.sv */
// Top level of the D2Q9 BGK collision unit with forcing, one lattice cell per request.
//
// Usage
//   site   : request channel, nine populations plus force_x / force_y, Q8.24 signed.
//   result : nine post-collision populations, density and velocity, Q8.24 signed.
//   cfg_*  : plain write port; index 0 is relax_rate, index 1 is force_factor.
//            Write only while no request is in flight.
// Throughput: one request per cycle while the skid register is empty. Every unit is fully pipelined; the
//   34-stage velocity divider and the nine collision lanes each take a new cell a cycle.
// Pipeline: from the accepting edge a request passes 2 moment stages, 34 divider stages,
//   2 stages for |u|^2, 7 lane stages and the output register before its result is presented.
// Stall: a stalled result sits in the output register; one more result drops into a
//   skid register, and only then does site.ready fall and the whole pipeline freeze.
// Reset (arst_n low): valid bits, output and skid flags clear, registers return to
//   relax_rate = 1.0 and force_factor = 0.5. No clearing pass is needed.
// Density not positive: velocity reads zero and the collision runs with u = v = 0.
`include "assert_macros.svh"

module lbm_d2q9_moments_collide_forced_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [lbmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbmc_pkg::CFG_W-1:0]         cfg_data,
	lbmc_cell_if.sink                          site,
	lbmc_post_if.source                        result
);

	localparam int NP = lbmc_pkg::NPOP;

	// Configuration registers.
	logic [lbmc_pkg::RELAX_W-1:0] relax_q;
	logic [lbmc_pkg::FORCE_W-1:0] force_q;

	// Pipeline control.
	logic go;
	logic vld_s [lbmc_pkg::PIPE_LAT];

	// Moment stages.
	lbmc_pkg::q_t       in_f [NP];
	logic signed [63:0] sum_c, mx_c, my_c, nx_c, ny_c;
	logic signed [39:0] sum_s1, mx_s1, my_s1;
	lbmc_pkg::q_t       f_s1 [NP];
	lbmc_pkg::q_t       fx_s1, fy_s1;
	lbmc_pkg::q_t       rho_s2, fy_s2;
	lbmc_pkg::q_t       f_s2 [NP];
	logic signed [lbmc_pkg::NUM_W-1:0] nx_s2, ny_s2;

	// Divider outputs and the side data that travels alongside.
	lbmc_pkg::q_t       u_div, v_div;
	lbmc_pkg::side_t    side_c;
	lbmc_pkg::side_t    side_s [lbmc_pkg::SIDE_LAT];

	// Square-speed stages.
	lbmc_pkg::q_t       uu_s3, vv_s3, u_s3, v_s3;
	lbmc_pkg::q_t       u2_s4, u_s4, v_s4;

	// Lane outputs and the moments held back to meet them.
	lbmc_pkg::q_t       post_w [NP];
	lbmc_pkg::q_t       rho_t_s [lbmc_pkg::LANE_LAT];
	lbmc_pkg::q_t       u_t_s [lbmc_pkg::LANE_LAT];
	lbmc_pkg::q_t       v_t_s [lbmc_pkg::LANE_LAT];

	// Output register and skid.
	lbmc_pkg::post_t    res_c;
	lbmc_pkg::post_t    o_q, sk_q;
	logic               o_vld_q, sk_vld_q;

	// ---------------------------------------------------------------------
	// Configuration: take writes at any time, ignore unknown indexes.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= lbmc_pkg::RELAX_RESET;
			force_q <= lbmc_pkg::FORCE_RESET;
		end else if (cfg_write) begin
			case (lbmc_pkg::cfg_reg_t'(cfg_index))
				lbmc_pkg::CFG_RELAX_RATE:   relax_q <= cfg_data[lbmc_pkg::RELAX_W-1:0];
				lbmc_pkg::CFG_FORCE_FACTOR: force_q <= cfg_data[lbmc_pkg::FORCE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Flow control: the pipeline advances as a whole while the skid is free,
	// so ready never depends combinationally on result.ready.
	// ---------------------------------------------------------------------
	assign go         = !sk_vld_q;
	assign site.ready = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lbmc_pkg::PIPE_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (go) begin
			vld_s[0] <= site.valid;
			for (int k = 1; k < lbmc_pkg::PIPE_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: density sum and first moments.
	// ---------------------------------------------------------------------
	assign in_f[0] = site.pop_rest;
	assign in_f[1] = site.pop_east;
	assign in_f[2] = site.pop_east_south;
	assign in_f[3] = site.pop_south;
	assign in_f[4] = site.pop_west_south;
	assign in_f[5] = site.pop_west;
	assign in_f[6] = site.pop_west_north;
	assign in_f[7] = site.pop_north;
	assign in_f[8] = site.pop_east_north;

	always_comb begin
		sum_c = '0;
		mx_c  = '0;
		my_c  = '0;
		for (int p = 0; p < NP; p++) begin
			sum_c = sum_c + 64'(in_f[p]);
			if (lbmc_pkg::dir_x(4'(p)) == 2'sd1) begin
				mx_c = mx_c + 64'(in_f[p]);
			end else if (lbmc_pkg::dir_x(4'(p)) == -2'sd1) begin
				mx_c = mx_c - 64'(in_f[p]);
			end
			if (lbmc_pkg::dir_y(4'(p)) == 2'sd1) begin
				my_c = my_c + 64'(in_f[p]);
			end else if (lbmc_pkg::dir_y(4'(p)) == -2'sd1) begin
				my_c = my_c - 64'(in_f[p]);
			end
		end
		nx_c = 64'sd2 * 64'(mx_s1) + 64'(fx_s1);
		ny_c = 64'sd2 * 64'(my_s1) + 64'(fy_s1);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sum_s1 <= sum_c[39:0];
			mx_s1  <= mx_c[39:0];
			my_s1  <= my_c[39:0];
			fx_s1  <= site.force_x;
			fy_s1  <= site.force_y;
			for (int p = 0; p < NP; p++) begin
				f_s1[p] <= in_f[p];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: clamp density, form the divider numerators 2m + F.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (go) begin
			rho_s2 <= lbmc_pkg::sat32(64'(sum_s1));
			nx_s2  <= nx_c[lbmc_pkg::NUM_W-1:0];
			ny_s2  <= ny_c[lbmc_pkg::NUM_W-1:0];
			fy_s2  <= fy_s1;
			for (int p = 0; p < NP; p++) begin
				f_s2[p] <= f_s1[p];
			end
		end
	end

	// Velocity dividers, one per component.
	lbmc_div u_div_x (
		.clk (clk),
		.go  (go),
		.num (nx_s2),
		.rho (rho_s2),
		.quo (u_div)
	);

	lbmc_div u_div_y (
		.clk (clk),
		.go  (go),
		.num (ny_s2),
		.rho (rho_s2),
		.quo (v_div)
	);

	// Hold populations, force_y and density while the division runs.
	always_comb begin
		side_c.fy  = fy_s2;
		side_c.rho = rho_s2;
		for (int p = 0; p < NP; p++) begin
			side_c.f[p] = f_s2[p];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			side_s[0] <= side_c;
			for (int k = 1; k < lbmc_pkg::SIDE_LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stages 3 and 4: squared speed |u|^2, shared by all lanes.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (go) begin
			uu_s3 <= lbmc_pkg::mulq(u_div, u_div);
			vv_s3 <= lbmc_pkg::mulq(v_div, v_div);
			u_s3  <= u_div;
			v_s3  <= v_div;
			u2_s4 <= lbmc_pkg::sat32(64'(uu_s3) + 64'(vv_s3));
			u_s4  <= u_s3;
			v_s4  <= v_s3;
		end
	end

	// ---------------------------------------------------------------------
	// Nine collision lanes, one per lattice direction.
	// ---------------------------------------------------------------------
	for (genvar p = 0; p < NP; p++) begin : g_lane
		lbmc_lane u_lane (
			.clk   (clk),
			.go    (go),
			.dir   (4'(p)),
			.u     (u_s4),
			.v     (v_s4),
			.u2    (u2_s4),
			.rho   (side_s[lbmc_pkg::SIDE_LAT-1].rho),
			.f     (side_s[lbmc_pkg::SIDE_LAT-1].f[p]),
			.fy    (side_s[lbmc_pkg::SIDE_LAT-1].fy),
			.omega (relax_q),
			.ffac  (force_q),
			.post  (post_w[p])
		);
	end

	// Delay the moments to line up with the lane results.
	always_ff @(posedge clk) begin
		if (go) begin
			rho_t_s[0] <= side_s[lbmc_pkg::SIDE_LAT-1].rho;
			u_t_s[0]   <= u_s4;
			v_t_s[0]   <= v_s4;
			for (int k = 1; k < lbmc_pkg::LANE_LAT; k++) begin
				rho_t_s[k] <= rho_t_s[k-1];
				u_t_s[k]   <= u_t_s[k-1];
				v_t_s[k]   <= v_t_s[k-1];
			end
		end
	end

	// Merge: gather the lanes and the moments into one result.
	always_comb begin
		res_c.density = rho_t_s[lbmc_pkg::LANE_LAT-1];
		res_c.vel_x   = u_t_s[lbmc_pkg::LANE_LAT-1];
		res_c.vel_y   = v_t_s[lbmc_pkg::LANE_LAT-1];
		for (int p = 0; p < NP; p++) begin
			res_c.post[p] = post_w[p];
		end
	end

	// ---------------------------------------------------------------------
	// Output register with skid: refill from the skid first, park a fresh
	// result in the skid when the output is stalled.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q  <= 1'b0;
			sk_vld_q <= 1'b0;
		end else if (o_vld_q && !result.ready) begin
			if (go && vld_s[lbmc_pkg::PIPE_LAT-1]) begin
				sk_vld_q <= 1'b1;
			end
		end else if (sk_vld_q) begin
			o_vld_q  <= 1'b1;
			sk_vld_q <= 1'b0;
		end else begin
			o_vld_q <= vld_s[lbmc_pkg::PIPE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (o_vld_q && !result.ready) begin
			if (go && vld_s[lbmc_pkg::PIPE_LAT-1]) begin
				sk_q <= res_c;
			end
		end else if (sk_vld_q) begin
			o_q <= sk_q;
		end else begin
			o_q <= res_c;
		end
	end

	assign result.valid           = o_vld_q;
	assign result.post_rest       = o_q.post[0];
	assign result.post_east       = o_q.post[1];
	assign result.post_east_south = o_q.post[2];
	assign result.post_south      = o_q.post[3];
	assign result.post_west_south = o_q.post[4];
	assign result.post_west       = o_q.post[5];
	assign result.post_west_north = o_q.post[6];
	assign result.post_north      = o_q.post[7];
	assign result.post_east_north = o_q.post[8];
	assign result.density         = o_q.density;
	assign result.velocity_x      = o_q.vel_x;
	assign result.velocity_y      = o_q.vel_y;

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`LBMC_ASSERT(a_skid_behind_out, sk_vld_q |-> o_vld_q, "skid holds a result while output is empty")
	`LBMC_ASSERT(a_stall_freezes, !go |=> $stable(vld_s[lbmc_pkg::PIPE_LAT-1]), "pipeline moved while stalled")
	`LBMC_ASSERT(a_no_drop, (go && vld_s[lbmc_pkg::PIPE_LAT-1] && o_vld_q && !result.ready) |=> sk_vld_q, "result lost at a stalled output")
	`LBMC_ASSERT(a_skid_cause, $rose(sk_vld_q) |-> $past(o_vld_q && !result.ready), "skid filled without a stall")
	`LBMC_ASSERT_RST(a_reset_empty, !o_vld_q && !sk_vld_q, "output not empty in reset")

endmodule

/* src/lbmc_div.sv */
// Pipelined restoring divider: velocity = num * 2^24 / (2 * rho), one bit a stage.
module lbmc_div (
	input  logic                                clk,
	input  logic                                go,
	input  logic signed [lbmc_pkg::NUM_W-1:0]   num,
	input  lbmc_pkg::q_t                        rho,
	output lbmc_pkg::q_t                        quo
);

	localparam int QB = lbmc_pkg::QW;

	logic [QB-1:0]           rem_s [QB+1];
	logic [QB-1:0]           lo_s  [QB+1];
	logic [QB-1:0]           quo_s [QB+1];
	logic [QB-1:0]           den_s [QB+1];
	logic                    neg_s [QB+1];
	logic                    pos_s [QB+1];
	logic                    ovf_s [QB+1];
	logic [lbmc_pkg::NUM_W-1:0] mag_c;
	logic [QB-1:0]           hi_c;
	logic [QB-1:0]           den_c;
	lbmc_pkg::q_t            res_c;
	lbmc_pkg::q_t            res_s;

	// Magnitude of the numerator; the low 24 bits of num * 2^24 are zero.
	always_comb begin
		mag_c = num[lbmc_pkg::NUM_W-1] ? (~num + 1'b1) : num;
		hi_c  = QB'(mag_c[lbmc_pkg::NUM_W-2:8]);
		den_c = {rho[QB-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_s[0] <= hi_c;
			lo_s[0]  <= {mag_c[7:0], 24'd0};
			quo_s[0] <= '0;
			den_s[0] <= den_c;
			neg_s[0] <= num[lbmc_pkg::NUM_W-1];
			pos_s[0] <= !rho[QB-1] && (rho != '0);
			ovf_s[0] <= hi_c >= den_c;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_bit
		logic [QB:0] r_c;
		logic [QB:0] d_c;
		logic        ge_c;

		assign r_c  = {rem_s[k-1], lo_s[k-1][QB-1]};
		assign d_c  = r_c - {1'b0, den_s[k-1]};
		assign ge_c = r_c >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (go) begin
				rem_s[k] <= ge_c ? d_c[QB-1:0] : r_c[QB-1:0];
				lo_s[k]  <= {lo_s[k-1][QB-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QB-2:0], ge_c};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				pos_s[k] <= pos_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// Apply sign, clamp, and force zero where density is not positive.
	always_comb begin
		if (!pos_s[QB]) begin
			res_c = '0;
		end else if (neg_s[QB]) begin
			res_c = (ovf_s[QB] || (quo_s[QB] > 32'h80000000)) ? lbmc_pkg::Q_MIN
				: lbmc_pkg::q_t'(32'd0 - quo_s[QB]);
		end else begin
			res_c = (ovf_s[QB] || quo_s[QB][QB-1]) ? lbmc_pkg::Q_MAX
				: lbmc_pkg::q_t'(quo_s[QB]);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_s <= res_c;
		end
	end

	assign quo = res_s;

endmodule

/* src/lbmc_lane.sv */
// One collision lane: equilibrium, forcing source and BGK relaxation of one population.
module lbmc_lane (
	input  logic                               clk,
	input  logic                               go,
	input  logic [3:0]                         dir,
	input  lbmc_pkg::q_t                       u,
	input  lbmc_pkg::q_t                       v,
	input  lbmc_pkg::q_t                       u2,
	input  lbmc_pkg::q_t                       rho,
	input  lbmc_pkg::q_t                       f,
	input  lbmc_pkg::q_t                       fy,
	input  logic [lbmc_pkg::RELAX_W-1:0]       omega,
	input  logic [lbmc_pkg::FORCE_W-1:0]       ffac,
	output lbmc_pkg::q_t                       post
);

	logic signed [1:0]  cx;
	logic signed [1:0]  cy;
	lbmc_pkg::q_t       w;

	logic signed [63:0] ux_c, vy_c, cyone_c, cyuc_c, t_c, poly_c, d_c, om_c, prod_c;
	logic signed [63:0] rr_c, post_c;

	lbmc_pkg::q_t uc_s1, v_s1, u2_s1, rho_s1, f_s1, fy_s1;
	lbmc_pkg::q_t uc_s2, uc2_s2, t_s2, u2_s2, rho_s2, f_s2, fy_s2;
	lbmc_pkg::q_t poly_s3, tf_s3, rho_s3, f_s3;
	lbmc_pkg::q_t rp_s4, sw_s4, f_s4;
	lbmc_pkg::q_t eq_s5, src_s5, f_s5;
	logic signed [39:0] rr_s6;
	lbmc_pkg::q_t src_s6, f_s6;
	lbmc_pkg::q_t post_s7;

	assign cx = lbmc_pkg::dir_x(dir);
	assign cy = lbmc_pkg::dir_y(dir);
	assign w  = lbmc_pkg::weight(dir);

	always_comb begin
		ux_c    = (cx == 2'sd1) ? 64'(u) : ((cx == -2'sd1) ? -64'(u) : 64'sd0);
		vy_c    = (cy == 2'sd1) ? 64'(v) : ((cy == -2'sd1) ? -64'(v) : 64'sd0);
		cyone_c = (cy == 2'sd1) ? 64'sd16777216
			: ((cy == -2'sd1) ? -64'sd16777216 : 64'sd0);
		cyuc_c  = (cy == 2'sd1) ? 64'sd9 * 64'(uc_s1)
			: ((cy == -2'sd1) ? -64'sd9 * 64'(uc_s1) : 64'sd0);
		t_c     = 64'sd3 * (cyone_c - 64'(v_s1)) + cyuc_c;
		poly_c  = 64'sd33554432 + 64'sd6 * 64'(uc_s2) + 64'sd9 * 64'(uc2_s2)
			- 64'sd3 * 64'(u2_s2) + 64'sd1;
		d_c     = 64'(eq_s5) - 64'(f_s5);
		om_c    = {38'd0, omega};
		prod_c  = om_c * d_c;
		rr_c    = (prod_c + 64'sd8388608) >>> 24;
		post_c  = 64'(f_s6) + 64'(rr_s6) + 64'(src_s6);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			uc_s1   <= lbmc_pkg::sat32(ux_c + vy_c);
			v_s1    <= v;
			u2_s1   <= u2;
			rho_s1  <= rho;
			f_s1    <= f;
			fy_s1   <= fy;

			uc_s2   <= uc_s1;
			uc2_s2  <= lbmc_pkg::mulq(uc_s1, uc_s1);
			t_s2    <= lbmc_pkg::sat32(t_c);
			u2_s2   <= u2_s1;
			rho_s2  <= rho_s1;
			f_s2    <= f_s1;
			fy_s2   <= fy_s1;

			poly_s3 <= lbmc_pkg::sat32(poly_c >>> 1);
			tf_s3   <= lbmc_pkg::mulq(t_s2, fy_s2);
			rho_s3  <= rho_s2;
			f_s3    <= f_s2;

			rp_s4   <= lbmc_pkg::mulq(rho_s3, poly_s3);
			sw_s4   <= lbmc_pkg::mulq(w, tf_s3);
			f_s4    <= f_s3;

			eq_s5   <= lbmc_pkg::mulq(w, rp_s4);
			src_s5  <= lbmc_pkg::mulq(lbmc_pkg::q_t'({7'd0, ffac}), sw_s4);
			f_s5    <= f_s4;

			rr_s6   <= rr_c[39:0];
			src_s6  <= src_s5;
			f_s6    <= f_s5;

			post_s7 <= lbmc_pkg::sat32(post_c);
		end
	end

	assign post = post_s7;

endmodule

/* verif/lbm_d2q9_moments_collide_forced_unit_test.sv */
// Self-checking testbench for the D2Q9 forced BGK collision unit.
`timescale 1ns / 1ps

module lbm_d2q9_moments_collide_forced_unit_test;
	import lbmc_pkg::*;

	localparam longint ONE = 64'sd16777216;
	localparam int MAX_SHOWN = 10;

	// One lattice cell as it enters, and the collided cell as it should leave.
	typedef struct {
		q_t f [NPOP];
		q_t fx;
		q_t fy;
	} cell_req_t;

	typedef struct {
		q_t v [NPOP+3];
	} collided_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	lbmc_cell_if site ();
	lbmc_post_if result ();

	lbm_d2q9_moments_collide_forced_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.site      (site.sink),
		.result    (result.source)
	);

	// Requests waiting for the driver, and collided cells waiting for the monitor.
	cell_req_t cell_backlog [$];
	collided_t post_due [$];

	// Mirror of the two registers, updated when a write lands.
	longint relax_mirror;
	longint force_mirror;

	int mismatches;
	int cells_sent;
	int cells_checked;
	int degenerate_cells;
	bit cell_took;
	int burst_left;
	int gap_left;
	int stall_mode;
	int stall_left;
	int stall_cycle;

	// Direction tables and weights of D2Q9, in request order.
	const int cx [NPOP] = '{0, 1, 1, 0, -1, -1, -1, 0, 1};
	const int cy [NPOP] = '{0, 0, -1, -1, -1, 0, 1, 1, 1};
	const longint wgt [NPOP] = '{7456540, 1864135, 466034, 1864135, 466034,
		1864135, 466034, 1864135, 466034};
	const string field_name [NPOP+3] = '{"post_rest", "post_east", "post_east_south",
		"post_south", "post_west_south", "post_west", "post_west_north", "post_north",
		"post_east_north", "density", "velocity_x", "velocity_y"};

	always #6 clk = ~clk;

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (x < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// Q8.24 product, rounded half up (arithmetic shift is a floor), clamped.
	function automatic longint qmul(input longint a, input longint b);
		return clamp32((a * b + 64'sd8388608) >>> 24);
	endfunction

	// Work out the collided cell: moments, velocity, equilibrium, forcing, relaxation.
	function automatic collided_t collide_cell(input cell_req_t c, input longint om,
			input longint ff);
		collided_t r;
		longint f [NPOP];
		longint sum, mx, my, rho, u, v, u2, fx, fy, uc, poly, eq, t, src, post;
		sum = 0;
		mx = 0;
		my = 0;
		u = 0;
		v = 0;
		for (int p = 0; p < NPOP; p++) begin
			f[p] = longint'(c.f[p]);
			sum += f[p];
			mx += cx[p] * f[p];
			my += cy[p] * f[p];
		end
		fx = longint'(c.fx);
		fy = longint'(c.fy);
		rho = clamp32(sum);
		// Empty or negative cell: no division, collide at rest.
		if (rho > 0) begin
			u = clamp32(((2 * mx + fx) * ONE) / (2 * rho));
			v = clamp32(((2 * my + fy) * ONE) / (2 * rho));
		end
		u2 = clamp32(qmul(u, u) + qmul(v, v));
		for (int p = 0; p < NPOP; p++) begin
			uc = clamp32(cx[p] * u + cy[p] * v);
			poly = clamp32((2 * ONE + 6 * uc + 9 * qmul(uc, uc) - 3 * u2 + 1) >>> 1);
			eq = qmul(wgt[p], qmul(rho, poly));
			t = clamp32(3 * (cy[p] * ONE - v) + 9 * cy[p] * uc);
			src = qmul(ff, qmul(wgt[p], qmul(t, fy)));
			post = clamp32(f[p] + ((om * (eq - f[p]) + 64'sd8388608) >>> 24) + src);
			r.v[p] = q_t'(post);
		end
		r.v[NPOP] = q_t'(rho);
		r.v[NPOP+1] = q_t'(u);
		r.v[NPOP+2] = q_t'(v);
		return r;
	endfunction

	function automatic q_t pick_extreme();
		case ($urandom_range(0, 5))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return q_t'(ONE);
			4: return -q_t'(ONE);
			default: return q_t'($urandom);
		endcase
	endfunction

	// Build a random cell. Most are physical: near equilibrium at a density around
	// one, with small forces. The rest are raw noise, extreme mixes or thin cells.
	function automatic cell_req_t random_cell();
		cell_req_t c;
		int kind;
		longint rho, noise, ux, uy;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			rho = longint'($urandom_range(1 << 22, 1 << 26));
			noise = longint'($urandom_range(0, 1 << 21));
			ux = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
			uy = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
			for (int p = 0; p < NPOP; p++) begin
				c.f[p] = q_t'(((wgt[p] * rho) >>> 24)
					+ ((((wgt[p] * rho) >>> 24) * 3 * (cx[p] * ux + cy[p] * uy)) >>> 24)
					+ longint'($urandom_range(0, 32'(2 * noise))) - noise);
			end
			c.fx = q_t'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
			c.fy = q_t'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
		end else if (kind < 80) begin
			for (int p = 0; p < NPOP; p++) c.f[p] = q_t'($urandom);
			c.fx = q_t'($urandom);
			c.fy = q_t'($urandom);
		end else if (kind < 92) begin
			for (int p = 0; p < NPOP; p++) c.f[p] = pick_extreme();
			c.fx = pick_extreme();
			c.fy = pick_extreme();
		end else begin
			// Thin cell: density near zero, often not positive.
			for (int p = 0; p < NPOP; p++) begin
				c.f[p] = q_t'(longint'($urandom_range(0, 1 << 16)) - (1 << 15));
			end
			c.fx = q_t'($urandom);
			c.fy = q_t'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
		end
		return c;
	endfunction

	function automatic cell_req_t flat_cell(input q_t val, input q_t fx, input q_t fy);
		cell_req_t c;
		for (int p = 0; p < NPOP; p++) c.f[p] = val;
		c.fx = fx;
		c.fy = fy;
		return c;
	endfunction

	// Edge cases first: empty cell, negative density, saturating sums, unit
	// density at rest, a strong one-sided cell, and the force extremes.
	task automatic queue_directed();
		cell_req_t c;
		cell_backlog.push_back(flat_cell('0, '0, '0));
		cell_backlog.push_back(flat_cell(-q_t'(ONE), Q_MAX, Q_MIN));
		cell_backlog.push_back(flat_cell(Q_MAX, Q_MAX, Q_MAX));
		cell_backlog.push_back(flat_cell(Q_MIN, Q_MIN, Q_MIN));
		cell_backlog.push_back(flat_cell(Q_MAX, Q_MIN, Q_MAX));
		cell_backlog.push_back(flat_cell(q_t'(ONE / 9), '0, '0));
		cell_backlog.push_back(flat_cell(q_t'(ONE / 9), Q_MAX, Q_MIN));
		cell_backlog.push_back(flat_cell(q_t'(ONE / 9), Q_MIN, Q_MAX));
		cell_backlog.push_back(flat_cell(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555));
		cell_backlog.push_back(flat_cell(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA));
		cell_backlog.push_back(flat_cell(32'sd1, -32'sd1, 32'sd1));
		// All mass moving east, then all moving north: large velocities.
		c = flat_cell('0, '0, '0);
		c.f[1] = q_t'(ONE);
		cell_backlog.push_back(c);
		c = flat_cell('0, q_t'(ONE), -q_t'(ONE));
		c.f[7] = q_t'(ONE);
		c.f[0] = 32'sd1;
		cell_backlog.push_back(c);
		// Tiny positive density with a huge moment: velocity saturates.
		c = flat_cell('0, Q_MAX, Q_MAX);
		c.f[8] = 32'sd1;
		cell_backlog.push_back(c);
		// Zero density from cancelling populations with a nonzero force.
		c = flat_cell('0, q_t'(ONE), q_t'(ONE));
		c.f[1] = q_t'(ONE);
		c.f[5] = -q_t'(ONE);
		cell_backlog.push_back(c);
	endtask

	// Hold until every queued cell is sent and every result has come back, then
	// let the pipeline drain before touching the registers.
	task automatic wait_idle();
		while (cell_backlog.size() != 0 || post_due.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic run_phase(input int count);
		for (int i = 0; i < count; i++) cell_backlog.push_back(random_cell());
		wait_idle();
	endtask

	// Track acceptances, register writes and predictions on the rising edge.
	always @(posedge clk) begin
		cell_took = 1'b0;
		if (arst_n && cfg_write) begin
			if (cfg_index == CFG_RELAX_RATE) begin
				relax_mirror = longint'(cfg_data[RELAX_W-1:0]);
			end else begin
				force_mirror = longint'(cfg_data[FORCE_W-1:0]);
			end
		end
		if (arst_n && site.valid && site.ready) begin
			cell_req_t c;
			c = cell_backlog.pop_front();
			post_due.push_back(collide_cell(c, relax_mirror, force_mirror));
			if (longint'(c.f[0]) + c.f[1] + c.f[2] + c.f[3] + c.f[4] + c.f[5] + c.f[6]
					+ c.f[7] + c.f[8] <= 0) begin
				degenerate_cells++;
			end
			cells_sent++;
			cell_took = 1'b1;
		end
	end

	// Compare each result with the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			collided_t got, want;
			got.v = '{result.post_rest, result.post_east, result.post_east_south,
				result.post_south, result.post_west_south, result.post_west,
				result.post_west_north, result.post_north, result.post_east_north,
				result.density, result.velocity_x, result.velocity_y};
			if (post_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) $display("result with no request pending");
			end else begin
				want = post_due.pop_front();
				for (int k = 0; k < NPOP + 3; k++) begin
					if (got.v[k] !== want.v[k]) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN) begin
							$display("cell %0d %s: expected %h, got %h", cells_checked,
								field_name[k], want.v[k], got.v[k]);
						end
					end
				end
			end
			cells_checked++;
		end
	end

	// Driver: hold a request until taken, send in bursts with random gaps.
	always @(negedge clk) begin
		if (arst_n && !(site.valid && !cell_took)) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
					: $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
			end
			if (burst_left > 0 && cell_backlog.size() != 0) begin
				site.valid <= 1'b1;
				{site.pop_rest, site.pop_east, site.pop_east_south, site.pop_south,
					site.pop_west_south, site.pop_west, site.pop_west_north,
					site.pop_north, site.pop_east_north} <= {cell_backlog[0].f[0],
					cell_backlog[0].f[1], cell_backlog[0].f[2], cell_backlog[0].f[3],
					cell_backlog[0].f[4], cell_backlog[0].f[5], cell_backlog[0].f[6],
					cell_backlog[0].f[7], cell_backlog[0].f[8]};
				site.force_x <= cell_backlog[0].fx;
				site.force_y <= cell_backlog[0].fy;
				burst_left--;
			end else begin
				site.valid <= 1'b0;
				if (burst_left > 0) begin
					burst_left = 0;
				end else if (gap_left > 0) begin
					gap_left--;
				end
			end
		end
	end

	// Receiver: switch modes periodically between always ready, random
	// stalls and long stalls, so the skid path and full freeze are both hit.
	always @(negedge clk) begin
		if (arst_n) begin
			stall_cycle++;
			if (stall_cycle % 300 == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: result.ready <= 1'b1;
				1: result.ready <= 1'($urandom_range(0, 1));
				default: begin
					if (stall_left == 0) stall_left = $urandom_range(1, 60);
					stall_left--;
					result.ready <= (stall_left < 8);
				end
			endcase
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_RELAX_RATE;
		cfg_data = '0;
		site.valid = 1'b0;
		{site.pop_rest, site.pop_east, site.pop_east_south, site.pop_south,
			site.pop_west_south, site.pop_west, site.pop_west_north, site.pop_north,
			site.pop_east_north, site.force_x, site.force_y} = '0;
		result.ready = 1'b0;
		relax_mirror = longint'(RELAX_RESET);
		force_mirror = longint'(FORCE_RESET);
		mismatches = 0;
		cells_sent = 0;
		cells_checked = 0;
		degenerate_cells = 0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		stall_left = 0;
		stall_cycle = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values first, then zero, top of range, all ones and random.
		queue_directed();
		run_phase(300);
		write_reg(CFG_RELAX_RATE, '0);
		write_reg(CFG_FORCE_FACTOR, '0);
		queue_directed();
		run_phase(250);
		write_reg(CFG_RELAX_RATE, 26'd33554432);
		write_reg(CFG_FORCE_FACTOR, 26'd16777216);
		queue_directed();
		run_phase(250);
		write_reg(CFG_RELAX_RATE, '1);
		write_reg(CFG_FORCE_FACTOR, '1);
		run_phase(200);
		write_reg(CFG_RELAX_RATE, 26'($urandom_range(0, 33554432)));
		write_reg(CFG_FORCE_FACTOR, 26'($urandom_range(0, 16777216)));
		run_phase(250);
		write_reg(CFG_RELAX_RATE, 26'($urandom_range(8388608, 33554432)));
		write_reg(CFG_FORCE_FACTOR, 26'($urandom_range(0, 16777216)));
		run_phase(200);

		$display("Sent %0d cells (%0d with non-positive density) over six register settings,",
			cells_sent, degenerate_cells);
		$display("checked %0d results under mixed burst gaps and output stalls.",
			cells_checked);
		if (mismatches == 0 && post_due.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, post_due.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", post_due.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
